FILE: rtl/loop_period_statistics_defines.svh
// Assertion macros for the loop-period statistics RTL.
`ifndef LOOP_PERIOD_STATISTICS_DEFINES_SVH
`define LOOP_PERIOD_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lps_pkg.sv
// Types and constants for the loop-period statistics block.
package lps_pkg;

  localparam int unsigned PeriodBits  = 32;
  localparam int unsigned AtBits      = 24;
  localparam int unsigned CountBits   = 24;
  localparam int unsigned VarBits     = 64;
  localparam int unsigned IndexBits   = 24;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 32;

  // Operation codes
  localparam logic OpSample = 1'b0;
  localparam logic OpStart  = 1'b1;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegNominalPeriod = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegSampleCount   = 2'd1;

  // Reset values
  localparam logic [PeriodBits-1:0] NominalPeriodReset = 32'd256000;
  localparam logic [CountBits-1:0]  SampleCountReset   = 24'd1000;

  typedef struct packed {
    logic                  operation;
    logic [PeriodBits-1:0] interval;
  } in_beat_t;

  typedef struct packed {
    logic [PeriodBits-1:0] mean_period;
    logic [PeriodBits-1:0] std_dev;
    logic [PeriodBits-1:0] max_period;
    logic [AtBits-1:0]     max_at;
    logic [PeriodBits-1:0] min_period;
    logic [AtBits-1:0]     min_at;
  } out_beat_t;

endpackage

FILE: rtl/loop_period_statistics.sv
// Loop-period jitter monitor: running mean, variance, min and max over a run.
//
// A start beat arms a run and seeds mean, min and max with nominal_period; it
// is taken without a stall. Each interval beat of an armed run holds the input
// stalled through a bit-serial mean divider (divide by index+1) followed by a
// shift-add squarer, while a bit-serial variance divider (divide by index) runs
// alongside both; then a shift-add scale by index+1 and the 64-bit update in
// the keep and add states. The last sample of a run adds a two-bit-per-cycle
// square root and a load of the output register. A finished result waits in
// that register while the next beats are taken; the input stalls only if a
// second result is ready before the first has been taken. Samples while
// disarmed, or beyond sample_count, are taken without a stall and give no result.
`include "loop_period_statistics_defines.svh"

module loop_period_statistics #(
  parameter int unsigned INDEX_BITS = lps_pkg::IndexBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lps_pkg::in_beat_t                   in_data_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lps_pkg::out_beat_t                  out_data_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lps_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [lps_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import lps_pkg::*;

  localparam int unsigned Ib   = INDEX_BITS;
  localparam int unsigned CmpW = 33;
  localparam int unsigned MulW = (Ib + 1 > PeriodBits) ? Ib + 1 : PeriodBits;
  localparam int unsigned CntW = 6;
  localparam int unsigned RemW = 35;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SQR, ST_SCALE, ST_KEEP, ST_ADD, ST_ROOT, ST_EMIT
  } state_e;

  // Control and architectural state
  state_e                state_q;
  logic [CntW-1:0]       cnt_q;
  logic                  armed_q;
  logic [Ib-1:0]         sample_index_q;
  logic [PeriodBits-1:0] running_mean_q;
  logic [VarBits-1:0]    running_variance_q;
  logic [PeriodBits-1:0] largest_q, smallest_q;
  logic [AtBits-1:0]     largest_at_q, smallest_at_q;
  logic [PeriodBits-1:0] nominal_period_q;
  logic [CountBits-1:0]  sample_count_q;
  logic                  out_valid_q;
  out_beat_t             out_q;

  // Datapath shift registers
  logic [Ib:0]           ip1_q;       // index + 1
  logic                  mean_up_q;
  logic [PeriodBits-1:0] md_a_q;      // mean dividend, becomes quotient
  logic [Ib:0]           md_rem_q;
  logic [VarBits-1:0]    vd_q_q;      // variance dividend, becomes quotient
  logic [Ib-1:0]         vd_rem_q;
  logic [VarBits-1:0]    mul_acc_q, mul_cand_q;
  logic [MulW-1:0]       mul_plier_q;
  logic                  mul_sat_q;
  logic [VarBits-1:0]    sq_v_q;
  logic [RemW-1:0]       sq_rem_q;
  logic [PeriodBits-1:0] sq_root_q;

  logic in_acc, out_acc, sample_ok, last;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // Run bounds
  logic [CmpW-1:0] idx_ext, cnt_ext;
  assign idx_ext   = CmpW'(sample_index_q);
  assign cnt_ext   = CmpW'(sample_count_q);
  assign sample_ok = armed_q && (sample_index_q != '0) && (idx_ext <= cnt_ext);
  assign last      = (idx_ext == cnt_ext);

  // Mean divider step: divide by index + 1
  logic [Ib+1:0] md_sh, md_sub;
  logic          md_ge;
  assign md_sh  = {md_rem_q, md_a_q[PeriodBits-1]};
  assign md_ge  = md_sh >= {1'b0, ip1_q};
  assign md_sub = md_sh - {1'b0, ip1_q};

  // Variance divider step: divide by index
  logic [Ib:0] vd_sh, vd_sub;
  logic        vd_ge;
  assign vd_sh  = {vd_rem_q, vd_q_q[VarBits-1]};
  assign vd_ge  = vd_sh >= {1'b0, sample_index_q};
  assign vd_sub = vd_sh - {1'b0, sample_index_q};

  // Shift-add multiplier step, MSB of multiplier first, sticky saturation
  logic [VarBits:0]   mul_sum;
  logic [VarBits-1:0] mul_acc_d;
  logic               mul_sat_d;
  assign mul_sum   = {1'b0, mul_acc_q[VarBits-2:0], 1'b0}
                   + {1'b0, (mul_plier_q[MulW-1] ? mul_cand_q : '0)};
  assign mul_acc_d = mul_sum[VarBits-1:0];
  assign mul_sat_d = mul_sat_q | mul_acc_q[VarBits-1] | mul_sum[VarBits];

  // Saturating variance update
  logic [VarBits-1:0] prod;
  logic [VarBits:0]   var_sum;
  logic [VarBits-1:0] var_new;
  assign prod    = mul_sat_q ? '1 : mul_acc_q;
  assign var_sum = {1'b0, vd_q_q} + {1'b0, prod};
  assign var_new = var_sum[VarBits] ? '1 : var_sum[VarBits-1:0];

  // Square root step, two bits per cycle
  logic [RemW-1:0] sq_sh, sq_trial;
  logic            sq_ge;
  assign sq_sh    = {sq_rem_q[32:0], sq_v_q[VarBits-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // Control, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      cnt_q              <= '0;
      armed_q            <= 1'b0;
      sample_index_q     <= Ib'(1);
      running_mean_q     <= '0;
      running_variance_q <= '0;
      largest_q          <= '0;
      smallest_q         <= '0;
      largest_at_q       <= '0;
      smallest_at_q      <= '0;
      nominal_period_q   <= NominalPeriodReset;
      sample_count_q     <= SampleCountReset;
      out_valid_q        <= 1'b0;
      out_q              <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegNominalPeriod) nominal_period_q <= cfg_data_i;
        if (cfg_index_i == RegSampleCount)   sample_count_q   <= cfg_data_i[CountBits-1:0];
      end
      // result register: loaded in emit, cleared once taken
      if (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data_i.operation == OpStart) begin
              running_mean_q     <= nominal_period_q;
              largest_q          <= nominal_period_q;
              smallest_q         <= nominal_period_q;
              running_variance_q <= '0;
              largest_at_q       <= '0;
              smallest_at_q      <= '0;
              sample_index_q     <= Ib'(1);
              armed_q            <= 1'b1;
            end else if (sample_ok) begin
              if (in_data_i.interval > largest_q) begin
                largest_q    <= in_data_i.interval;
                largest_at_q <= AtBits'(sample_index_q);
              end
              if (in_data_i.interval < smallest_q) begin
                smallest_q    <= in_data_i.interval;
                smallest_at_q <= AtBits'(sample_index_q);
              end
              cnt_q   <= CntW'(PeriodBits - 1);
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            // md_a_q holds all but the last quotient bit
            running_mean_q <= mean_up_q
                            ? running_mean_q + {md_a_q[PeriodBits-2:0], md_ge}
                            : running_mean_q - {md_a_q[PeriodBits-2:0], md_ge};
            cnt_q   <= CntW'(PeriodBits - 1);
            state_q <= ST_SQR;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_SQR: begin
          if (cnt_q == '0) begin
            cnt_q   <= CntW'(Ib);
            state_q <= ST_SCALE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_SCALE: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_KEEP;
        end
        ST_KEEP: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          running_variance_q <= var_new;
          sample_index_q     <= sample_index_q + 1'b1;
          if (last) begin
            armed_q <= 1'b0;
            cnt_q   <= CntW'(PeriodBits - 1);
            state_q <= ST_ROOT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_ROOT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.mean_period <= running_mean_q;
            out_q.std_dev     <= sq_root_q;
            out_q.max_period  <= largest_q;
            out_q.max_at      <= largest_at_q;
            out_q.min_period  <= smallest_q;
            out_q.min_at      <= smallest_at_q;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Bit-serial datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ip1_q     <= {1'b0, sample_index_q} + 1'b1;
          mean_up_q <= in_data_i.interval >= running_mean_q;
          md_a_q    <= (in_data_i.interval >= running_mean_q)
                     ? in_data_i.interval - running_mean_q
                     : running_mean_q - in_data_i.interval;
          md_rem_q  <= '0;
          vd_q_q    <= running_variance_q;
          vd_rem_q  <= '0;
        end
      end
      ST_DIV: begin
        md_rem_q <= md_ge ? md_sub[Ib:0] : md_sh[Ib:0];
        md_a_q   <= {md_a_q[PeriodBits-2:0], md_ge};
        vd_rem_q <= vd_ge ? vd_sub[Ib-1:0] : vd_sh[Ib-1:0];
        vd_q_q   <= {vd_q_q[VarBits-2:0], vd_ge};
        if (cnt_q == '0) begin
          // start squaring the mean step
          mul_cand_q  <= VarBits'({md_a_q[PeriodBits-2:0], md_ge});
          mul_plier_q <= MulW'({md_a_q[PeriodBits-2:0], md_ge}) << (MulW - PeriodBits);
          mul_acc_q   <= '0;
          mul_sat_q   <= 1'b0;
        end
      end
      ST_SQR: begin
        vd_rem_q <= vd_ge ? vd_sub[Ib-1:0] : vd_sh[Ib-1:0];
        vd_q_q   <= {vd_q_q[VarBits-2:0], vd_ge};
        if (cnt_q == '0) begin
          // square done, scale it by index + 1
          mul_cand_q  <= mul_acc_d;
          mul_plier_q <= MulW'(ip1_q) << (MulW - (Ib + 1));
          mul_acc_q   <= '0;
          mul_sat_q   <= 1'b0;
        end else begin
          mul_acc_q   <= mul_acc_d;
          mul_plier_q <= mul_plier_q << 1;
        end
      end
      ST_SCALE: begin
        mul_acc_q   <= mul_acc_d;
        mul_sat_q   <= mul_sat_d;
        mul_plier_q <= mul_plier_q << 1;
      end
      ST_KEEP: begin
        // floor(v * (i-1) / i) = v - ceil(v / i)
        vd_q_q <= running_variance_q - vd_q_q - VarBits'(vd_rem_q != '0);
      end
      ST_ADD: begin
        sq_v_q    <= var_new;
        sq_rem_q  <= '0;
        sq_root_q <= '0;
      end
      ST_ROOT: begin
        sq_rem_q  <= sq_ge ? sq_sh - sq_trial : sq_sh;
        sq_root_q <= {sq_root_q[PeriodBits-2:0], sq_ge};
        sq_v_q    <= sq_v_q << 2;
      end
      ST_EMIT: begin
        sq_v_q <= sq_v_q;
      end
      default: begin
        sq_v_q <= sq_v_q;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Checks
  `LPS_ASSERT_IMPL(a_div_armed, state_q == ST_DIV, armed_q, "sample in work while disarmed")
  `LPS_ASSERT_IMPL(a_min_le_max, armed_q, smallest_q <= largest_q, "min above max in a run")
  `LPS_ASSERT_IMPL(a_var_rem, state_q == ST_SCALE, vd_rem_q < sample_index_q,
                   "variance remainder not below index")
  `LPS_ASSERT_NEXT(a_emit_src, !out_valid_q && state_q != ST_EMIT, !out_valid_q,
                   "result loaded outside emit")

endmodule

FILE: test/tb.sv
// Self-checking testbench for loop_period_statistics: directed table, then random runs.
module tb;
  import lps_pkg::*;

  localparam int unsigned ClkHalf       = 10;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned ItemsTarget   = 1500;
  localparam int unsigned SettleCycles  = 160;  // one sample plus the final root, with margin
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned NumRows       = 37;

  localparam logic [PeriodBits-1:0] AllOnes   = 32'hFFFF_FFFF;
  localparam logic [PeriodBits-1:0] Ignored   = 32'h5A5A_5A5A;  // interval field on a start
  // Register indexes past the end of the map; writes there must change nothing
  localparam logic [CfgIdxBits-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegSpare3 = 2'd3;

  typedef enum logic [1:0] {RowWrite, RowStart, RowSample} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIdxBits-1:0]    target;  // register, writes only
    logic [CfgDataBits-1:0]   value;   // register data or interval
    bit                       typed;   // result below is the expectation
    out_beat_t                result;
  } step_row_t;

  // Directed stimulus
  step_row_t steps [NumRows] = '{
    '{RowSample, RegNominalPeriod, 32'd256000, 1'b0, '0},   // disarmed after reset
    '{RowWrite,  RegSampleCount,   32'd1,      1'b0, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    // sample equal to the seed: ties keep index 0, no spread
    '{RowSample, RegNominalPeriod, 32'd256000, 1'b1,
      '{32'd256000, 32'd0, 32'd256000, 24'd0, 32'd256000, 24'd0}},
    '{RowWrite,  RegNominalPeriod, 32'd0,      1'b0, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd0,      1'b1, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, AllOnes,    1'b0, '0},
    '{RowWrite,  RegNominalPeriod, AllOnes,    1'b0, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, AllOnes,    1'b1,
      '{AllOnes, 32'd0, AllOnes, 24'd0, AllOnes, 24'd0}},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd0,      1'b0, '0},
    // zero count: armed but every sample is beyond the count
    '{RowWrite,  RegSampleCount,   32'd0,      1'b0, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd5,      1'b0, '0},
    '{RowWrite,  RegNominalPeriod, 32'd1000,   1'b0, '0},
    '{RowWrite,  RegSampleCount,   32'd2,      1'b0, '0},
    '{RowWrite,  RegSpare2,        32'd5,      1'b0, '0},
    '{RowWrite,  RegSpare3,        AllOnes,    1'b0, '0},
    // restart while armed
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd900,    1'b0, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd1100,   1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd700,    1'b0, '0},
    // count lowered under the running index, then raised to meet it
    '{RowWrite,  RegSampleCount,   32'd4,      1'b0, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd1200,   1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd800,    1'b0, '0},
    '{RowWrite,  RegSampleCount,   32'd2,      1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd1000,   1'b0, '0},
    '{RowWrite,  RegSampleCount,   32'd3,      1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd1000,   1'b0, '0},
    // upper data bits dropped: largest count
    '{RowWrite,  RegSampleCount,   AllOnes,    1'b0, '0},
    '{RowStart,  RegNominalPeriod, Ignored,    1'b0, '0},
    '{RowSample, RegNominalPeriod, 32'd1000,   1'b0, '0}
  };

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_beat_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_beat_t              out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i  = '0;

  // Statistics model state and registers, at their reset values
  logic                   run_armed   = 1'b0;
  logic [IndexBits-1:0]   run_index   = IndexBits'(1);
  logic [PeriodBits-1:0]  run_mean    = '0;
  logic [VarBits-1:0]     run_var     = '0;
  logic [PeriodBits-1:0]  run_max     = '0;
  logic [PeriodBits-1:0]  run_min     = '0;
  logic [AtBits-1:0]      run_max_at  = '0;
  logic [AtBits-1:0]      run_min_at  = '0;
  logic [PeriodBits-1:0]  nominal_reg = NominalPeriodReset;
  logic [CountBits-1:0]   count_reg   = SampleCountReset;

  out_beat_t   expected_stats[$];
  int unsigned errors       = 0;
  int unsigned items_taken  = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;  // no idling on either side while set

  loop_period_statistics u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Largest r with r*r <= v, one bit at a time from the top
  function automatic logic [PeriodBits-1:0] floor_root(input logic [VarBits-1:0] v);
    logic [PeriodBits-1:0] r;
    logic [PeriodBits-1:0] c;
    r = '0;
    for (int b = PeriodBits - 1; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (64'(c) * 64'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Advance the statistics by one accepted beat; returns 1 with the summary
  // when the beat closes a run. counted is set unless the beat was ignored.
  function automatic bit advance_stats(input in_beat_t b, output out_beat_t summary,
                                       output bit counted);
    logic [IndexBits-1:0] i;
    logic [63:0]          div;
    logic [63:0]          new_mean;
    logic [63:0]          d;
    logic [63:0]          d2;
    logic [63:0]          q;
    logic [63:0]          r;
    logic [63:0]          kept;
    logic [127:0]         scaled;
    logic [64:0]          total;
    summary = '0;
    counted = 1'b0;
    if (b.operation == OpStart) begin
      run_mean   = nominal_reg;
      run_max    = nominal_reg;
      run_min    = nominal_reg;
      run_var    = '0;
      run_max_at = '0;
      run_min_at = '0;
      run_index  = IndexBits'(1);
      run_armed  = 1'b1;
      counted    = 1'b1;
      return 1'b0;
    end
    i = run_index;
    if (!run_armed || i == '0 || i > count_reg) return 1'b0;
    counted = 1'b1;
    if (b.interval > run_max) begin
      run_max    = b.interval;
      run_max_at = AtBits'(i);
    end
    if (b.interval < run_min) begin
      run_min    = b.interval;
      run_min_at = AtBits'(i);
    end
    // mean moves toward the sample by diff/(i+1), truncated toward zero
    div = 64'(i) + 64'd1;
    if (b.interval >= run_mean)
      new_mean = 64'(run_mean) + (64'(b.interval) - 64'(run_mean)) / div;
    else
      new_mean = 64'(run_mean) - (64'(run_mean) - 64'(b.interval)) / div;
    d  = (new_mean >= 64'(run_mean)) ? new_mean - 64'(run_mean) : 64'(run_mean) - new_mean;
    d2 = d * d;
    // floor(v*(i-1)/i) is v minus the ceiling of v/i
    q      = run_var / 64'(i);
    r      = run_var % 64'(i);
    kept   = run_var - q - ((r != 0) ? 64'd1 : 64'd0);
    scaled = 128'(d2) * 128'(div);
    total  = 65'(kept) + ((scaled[127:64] != 0) ? 65'(AllOnes) << 32 | 65'(AllOnes)
                                                 : 65'(scaled[63:0]));
    run_mean  = new_mean[PeriodBits-1:0];
    run_var   = total[64] ? '1 : total[63:0];
    run_index = i + 1'b1;
    if (i == count_reg) begin
      run_armed           = 1'b0;
      summary.mean_period = run_mean;
      summary.std_dev     = floor_root(run_var);
      summary.max_period  = run_max;
      summary.max_at      = run_max_at;
      summary.min_period  = run_min;
      summary.min_at      = run_min_at;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [PeriodBits-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return AllOnes;
      2:       return '0;
      default: return nominal_reg + $urandom_range(0, 4096) - 32'd2048;  // jitter
    endcase
  endfunction

  function automatic logic [PeriodBits-1:0] pick_nominal();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return AllOnes;
      2:       return $urandom();
      default: return $urandom_range(2000, 1000000);
    endcase
  endfunction

  function automatic logic [CountBits-1:0] pick_count();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return SampleCountReset;
      3, 4:    return CountBits'($urandom_range(7, 30));
      default: return CountBits'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MaxReports) $display("tb: %s expected %0d got %0d", name, want, got);
    end
  endfunction

  // Offer one input beat, hold it until taken, then update the model
  task automatic send_beat(input logic op, input logic [PeriodBits-1:0] interval,
                           input bit typed, input out_beat_t typed_result);
    in_beat_t    b;
    out_beat_t   summary;
    bit          counted;
    int unsigned gap;
    gap         = draw_wait();
    b.operation = op;
    b.interval  = interval;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (advance_stats(b, summary, counted))
      expected_stats.push_back(typed ? typed_result : summary);
    if (counted) items_taken++;
  endtask

  // Drain pending results, then give an in-flight sample time to finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] index,
                           input logic [CfgDataBits-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      RegNominalPeriod: nominal_reg = data;
      RegSampleCount:   count_reg   = data[CountBits-1:0];
      default: ;
    endcase
  endtask

  // Result side: hold off a drawn number of cycles once a beat is waiting
  initial begin : result_side
    out_beat_t   want;
    int unsigned k;
    wait (rst_ni);
    forever begin
      k = draw_wait();
      if (k > 0) begin
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (k - 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_stats.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("tb: result with no run pending, mean %0d", out_data_o.mean_period);
      end else begin
        want = expected_stats.pop_front();
        check_field("mean_period", want.mean_period, out_data_o.mean_period);
        check_field("std_dev",     want.std_dev,     out_data_o.std_dev);
        check_field("max_period",  want.max_period,  out_data_o.max_period);
        check_field("max_at",      32'(want.max_at), 32'(out_data_o.max_at));
        check_field("min_period",  want.min_period,  out_data_o.min_period);
        check_field("min_at",      32'(want.min_at), 32'(out_data_o.min_at));
      end
    end
  end

  // Watchdog: too long without any beat taken on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned run_len;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[n]) begin
      case (steps[n].kind)
        RowWrite:  write_reg(steps[n].target, steps[n].value);
        RowStart:  send_beat(OpStart, steps[n].value, 1'b0, '0);
        RowSample: send_beat(OpSample, steps[n].value, steps[n].typed, steps[n].result);
        default: ;
      endcase
    end

    // Random runs: mostly complete runs, some cut short, some stray samples
    while (items_taken < ItemsTarget) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_reg(RegNominalPeriod, pick_nominal());
      if ($urandom_range(0, 2) == 0) write_reg(RegSampleCount, {8'($urandom()), pick_count()});
      if ($urandom_range(0, 19) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? RegSpare2 : RegSpare3, $urandom());
      if ($urandom_range(0, 9) == 0) send_beat(OpSample, $urandom(), 1'b0, '0);
      send_beat(OpStart, $urandom(), 1'b0, '0);
      run_len = (count_reg > 40) ? $urandom_range(1, 20) : 32'(count_reg);
      if (run_len > 0 && $urandom_range(0, 7) == 0) run_len = $urandom_range(0, run_len - 1);
      repeat (run_len) send_beat(OpSample, pick_interval(), 1'b0, '0);
      if ($urandom_range(0, 7) == 0) send_beat(OpSample, pick_interval(), 1'b0, '0);
    end

    wait_idle();
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lps_pkg.sv
rtl/loop_period_statistics.sv
test/tb.sv
